### hdl/plpt_pkg.sv
// ----------------------------------------------------------------------------
// plpt_pkg
// Shared widths, codes and control/status structures of the profile table.
// ----------------------------------------------------------------------------
package plpt_pkg;

   localparam int ELEV_W         = 24;
   localparam int DIST_W         = 24;
   localparam int COUNT_OUT_W    = 7;
   localparam int MAX_POINTS_DEF = 64;
   // Magnitude of (y1-y0)*(x-x0) plus margin.
   localparam int PROD_W         = 50;
   localparam int DIV_CNT_W      = 6;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef enum logic {
      RES_PREV,
      RES_INTERP
   } res_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        rd;
      logic        ld_prev;
      logic        ld_cur;
      logic        mod_eval;
      logic        wr_app;
      logic        wr_mod;
      logic        mul;
      logic        div_init;
      logic        div_step;
      logic        set_res;
      res_sel_type res_sel;
      logic        set_status;
      logic [1:0]  status;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       count_zero;
      logic       full;
      logic       idx_ge_count;
      logic       x_le_d;
      logic       dx_zero;
      logic       div_done;
   } sts_type;

endpackage

### hdl/plpt_ctrl.sv
// ----------------------------------------------------------------------------
// plpt_ctrl
// Sequencer for append, query walk, division and nearest-point modify.
// ----------------------------------------------------------------------------
module plpt_ctrl
   import plpt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_Q_LD0,
      S_Q_CHK,
      S_Q_EV,
      S_Q_MUL,
      S_Q_PRE,
      S_Q_DIV,
      S_M_EV,
      S_M_WR,
      S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd          = '0;
      cmd.res_sel  = RES_PREV;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FIN;
            unique case (sts.op)
               OP_APPEND: begin
                  if (sts.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                  end else begin
                     cmd.wr_app = 1'b1;
                  end
               end
               OP_QUERY: begin
                  if (sts.count_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else begin
                     cmd.rd   = 1'b1;
                     state_in = S_Q_LD0;
                  end
               end
               OP_MODIFY: begin
                  if (sts.count_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_EMPTY;
                  end else begin
                     cmd.rd   = 1'b1;
                     state_in = S_M_EV;
                  end
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end
         S_Q_LD0: begin
            cmd.ld_prev = 1'b1;
            state_in    = S_Q_CHK;
         end
         S_Q_CHK: begin
            if (sts.idx_ge_count) begin
               // Past the last point: answer with its elevation.
               cmd.set_res = 1'b1;
               cmd.res_sel = RES_PREV;
               state_in    = S_FIN;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_Q_EV;
            end
         end
         S_Q_EV: begin
            if (sts.x_le_d) begin
               cmd.ld_cur = 1'b1;
               state_in   = S_Q_MUL;
            end else begin
               cmd.ld_prev = 1'b1;
               state_in    = S_Q_CHK;
            end
         end
         S_Q_MUL: begin
            if (sts.dx_zero) begin
               cmd.set_res = 1'b1;
               cmd.res_sel = RES_PREV;
               state_in    = S_FIN;
            end else begin
               cmd.mul  = 1'b1;
               state_in = S_Q_PRE;
            end
         end
         S_Q_PRE: begin
            cmd.div_init = 1'b1;
            state_in     = S_Q_DIV;
         end
         S_Q_DIV: begin
            if (sts.div_done) begin
               cmd.set_res = 1'b1;
               cmd.res_sel = RES_INTERP;
               state_in    = S_FIN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_M_EV: begin
            cmd.mod_eval = 1'b1;
            if (sts.idx_ge_count) begin
               state_in = S_M_WR;
            end else begin
               cmd.rd = 1'b1;
            end
         end
         S_M_WR: begin
            cmd.wr_mod = 1'b1;
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/plpt_dp.sv
// ----------------------------------------------------------------------------
// plpt_dp
// Point memories, walk registers, multiplier, radix-2 divider and outputs.
// ----------------------------------------------------------------------------
module plpt_dp
   import plpt_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   output sts_type                        sts,
   input  logic [1:0]                     req_operation,
   input  logic [DIST_W-1:0]              req_distance,
   input  logic signed [ELEV_W-1:0]       req_elevation_in,
   output logic signed [ELEV_W-1:0]       rsp_elevation_out,
   output logic signed [ELEV_W-1:0]       rsp_highest,
   output logic signed [ELEV_W-1:0]       rsp_lowest,
   output logic [1:0]                     rsp_status,
   output logic [COUNT_OUT_W-1:0]         rsp_point_count
);

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int SUM_W = PROD_W + 2;

   logic [DIST_W-1:0]        dist_mem [MAX_POINTS];
   logic signed [ELEV_W-1:0] elev_mem [MAX_POINTS];

   logic [1:0]               op_ff;
   logic [DIST_W-1:0]        x_ff;
   logic signed [ELEV_W-1:0] e_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         idx_ff;
   logic [CNT_W-1:0]         rd_idx_ff;
   logic [DIST_W-1:0]        rd_dist_ff;
   logic signed [ELEV_W-1:0] rd_elev_ff;
   logic [DIST_W-1:0]        prev_d_ff, cur_d_ff;
   logic signed [ELEV_W-1:0] prev_e_ff, cur_e_ff;
   logic signed [ELEV_W-1:0] highest_ff, lowest_ff;
   logic                     first_ff;
   logic [DIST_W-1:0]        best_ad_ff;
   logic [CNT_W-1:0]         best_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0]        q_ff;
   logic [DIST_W+1:0]        rem_ff;
   logic [DIST_W:0]          dmag_ff;
   logic                     neg_ff;
   logic [DIV_CNT_W-1:0]     dcnt_ff;
   logic signed [ELEV_W-1:0] result_ff;
   logic [1:0]               status_ff;

   logic signed [ELEV_W-1:0] out_elev_ff, out_high_ff, out_low_ff;
   logic [1:0]               out_status_ff;
   logic [COUNT_OUT_W-1:0]   out_count_ff;

   logic signed [DIST_W:0]   dx, dxx;
   logic signed [ELEV_W:0]   dy;
   logic [DIST_W-1:0]        ad;
   logic [DIST_W+2:0]        rem_sh;
   logic signed [SUM_W-1:0]  q_signed, interp_sum;
   logic signed [ELEV_W-1:0] interp_sat;
   logic signed [ELEV_W-1:0] wr_e;
   logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

   assign dx  = $signed({1'b0, cur_d_ff}) - $signed({1'b0, prev_d_ff});
   assign dxx = $signed({1'b0, x_ff}) - $signed({1'b0, prev_d_ff});
   assign dy  = $signed({cur_e_ff[ELEV_W-1], cur_e_ff})
              - $signed({prev_e_ff[ELEV_W-1], prev_e_ff});
   assign ad  = (x_ff >= rd_dist_ff) ? (x_ff - rd_dist_ff) : (rd_dist_ff - x_ff);
   assign rem_sh = {rem_ff, q_ff[PROD_W-1]};

   assign q_signed   = neg_ff ? -$signed({2'b00, q_ff}) : $signed({2'b00, q_ff});
   assign interp_sum = $signed({{(SUM_W-ELEV_W){prev_e_ff[ELEV_W-1]}}, prev_e_ff})
                     + q_signed;

   always_comb begin
      if (interp_sum > $signed(SUM_W'(2**(ELEV_W-1) - 1))) begin
         interp_sat = {1'b0, {(ELEV_W-1){1'b1}}};
      end else if (interp_sum < -$signed(SUM_W'(2**(ELEV_W-1)))) begin
         interp_sat = {1'b1, {(ELEV_W-1){1'b0}}};
      end else begin
         interp_sat = interp_sum[ELEV_W-1:0];
      end
   end

   assign wr_e      = e_ff;
   assign count_ext = {{COUNT_OUT_W{1'b0}}, count_ff};

   assign sts.op           = op_ff;
   assign sts.count_zero   = (count_ff == '0);
   assign sts.full         = (count_ff >= CNT_W'(MAX_POINTS));
   assign sts.idx_ge_count = (idx_ff >= count_ff);
   assign sts.x_le_d       = (x_ff <= rd_dist_ff);
   assign sts.dx_zero      = (dx == '0);
   assign sts.div_done     = (dcnt_ff == '0);

   // Point storage, single write port and one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_app) begin
         dist_mem[count_ff[IDX_W-1:0]] <= x_ff;
         elev_mem[count_ff[IDX_W-1:0]] <= wr_e;
      end else if (cmd.wr_mod) begin
         elev_mem[best_ff[IDX_W-1:0]] <= wr_e;
      end
      if (cmd.rd) begin
         rd_dist_ff <= dist_mem[idx_ff[IDX_W-1:0]];
         rd_elev_ff <= elev_mem[idx_ff[IDX_W-1:0]];
         rd_idx_ff  <= idx_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         highest_ff <= {1'b1, {(ELEV_W-1){1'b0}}};
         lowest_ff  <= {1'b0, {(ELEV_W-1){1'b1}}};
         idx_ff     <= '0;
         dcnt_ff    <= '0;
      end else begin
         if (cmd.load_req) begin
            idx_ff <= '0;
         end else if (cmd.rd) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.wr_app) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.wr_app || cmd.wr_mod) begin
            if (wr_e > highest_ff) begin
               highest_ff <= wr_e;
            end
            if (wr_e < lowest_ff) begin
               lowest_ff <= wr_e;
            end
         end
         if (cmd.div_init) begin
            dcnt_ff <= DIV_CNT_W'(PROD_W);
         end else if (cmd.div_step) begin
            dcnt_ff <= dcnt_ff - 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff     <= req_operation;
         x_ff      <= req_distance;
         e_ff      <= req_elevation_in;
         result_ff <= '0;
         status_ff <= ST_OK;
         first_ff  <= 1'b1;
      end
      if (cmd.ld_prev) begin
         prev_d_ff <= rd_dist_ff;
         prev_e_ff <= rd_elev_ff;
      end
      if (cmd.ld_cur) begin
         cur_d_ff <= rd_dist_ff;
         cur_e_ff <= rd_elev_ff;
      end
      if (cmd.mod_eval && (first_ff || (ad < best_ad_ff))) begin
         first_ff   <= 1'b0;
         best_ad_ff <= ad;
         best_ff    <= rd_idx_ff;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(dy * dxx);
      end
      if (cmd.div_init) begin
         q_ff    <= prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : prod_ff;
         rem_ff  <= '0;
         dmag_ff <= dx[DIST_W] ? (DIST_W+1)'(-dx) : dx;
         neg_ff  <= prod_ff[PROD_W-1] ^ dx[DIST_W];
      end else if (cmd.div_step) begin
         // Restoring division, one quotient bit per cycle.
         if (rem_sh >= {2'b00, dmag_ff}) begin
            rem_ff <= (DIST_W+2)'(rem_sh - {2'b00, dmag_ff});
            q_ff   <= {q_ff[PROD_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DIST_W+1:0];
            q_ff   <= {q_ff[PROD_W-2:0], 1'b0};
         end
      end
      if (cmd.set_res) begin
         result_ff <= (cmd.res_sel == RES_INTERP) ? interp_sat : prev_e_ff;
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status;
      end
      if (cmd.out_load) begin
         out_elev_ff   <= result_ff;
         out_high_ff   <= highest_ff;
         out_low_ff    <= lowest_ff;
         out_status_ff <= status_ff;
         out_count_ff  <= count_ext[COUNT_OUT_W-1:0];
      end
   end

   assign rsp_elevation_out = out_elev_ff;
   assign rsp_highest       = out_high_ff;
   assign rsp_lowest        = out_low_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_point_count   = out_count_ff;

endmodule

### hdl/piecewise_linear_profile_table.sv
// ----------------------------------------------------------------------------
// piecewise_linear_profile_table
// Profile point table with append, linear interpolation query and modify.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  operation, distance, elevation_in
// rsp      out        rsp_valid/rsp_ready  elevation_out, highest, lowest,
//                                          status, point_count
//
// Append and every rejected transaction finish straight after dispatch; modify
// reads every stored point and then writes the nearest one. A query walks the
// points until one lies at or beyond its distance and may then interpolate
// (multiply, divider setup and one quotient bit per cycle).
// Reset is synchronous and needs no clearing pass. A new transaction is taken
// while the previous result waits on rsp; the finished result then waits too.
// ----------------------------------------------------------------------------
module piecewise_linear_profile_table
   import plpt_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_operation,
   input  logic [DIST_W-1:0]        req_distance,
   input  logic signed [ELEV_W-1:0] req_elevation_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [ELEV_W-1:0] rsp_elevation_out,
   output logic signed [ELEV_W-1:0] rsp_highest,
   output logic signed [ELEV_W-1:0] rsp_lowest,
   output logic [1:0]               rsp_status,
   output logic [COUNT_OUT_W-1:0]   rsp_point_count
);

   cmd_type cmd;
   sts_type sts;

   plpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   plpt_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_distance      (req_distance),
      .req_elevation_in  (req_elevation_in),
      .rsp_elevation_out (rsp_elevation_out),
      .rsp_highest       (rsp_highest),
      .rsp_lowest        (rsp_lowest),
      .rsp_status        (rsp_status),
      .rsp_point_count   (rsp_point_count)
   );

`ifndef SYNTHESIS
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3))
      else $error("invalid status code");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_elevation_out == '0))
      else $error("failed transaction carries a nonzero elevation");

   a_extrema_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_point_count != '0)) |-> (rsp_highest >= rsp_lowest))
      else $error("highest below lowest with stored points");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transaction accepted while busy");
`endif

endmodule
